FILE: hw/rtl/mcws_pkg.sv
`timescale 1ns / 1ps
package mcws_pkg;
  localparam int unsigned MaxPointsDefault = 1024;
  localparam int unsigned CoordBitsDefault = 20;
  localparam int unsigned SideBits = 20;
  localparam int unsigned WinBits = 11;

  localparam logic [0:0] RegMaxWindows = 1'b0;
  localparam logic [0:0] RegBoardWidth = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StInsRd,
    StInsChk,
    StSrchInit,
    StSrchMid,
    StCntStart,
    StCntRd,
    StCntChk,
    StSrchDec,
    StOut
  } mcws_state_e;

  typedef struct packed {
    logic load_pt;
    logic ins_rd;
    logic ins_shift;
    logic ins_place;
    logic srch_init;
    logic srch_mid;
    logic cnt_start;
    logic cnt_rd;
    logic cnt_step;
    logic srch_dec;
    logic clear_set;
  } mcws_cmd_t;

  typedef struct packed {
    logic store_full;
    logic ins_at_bottom;
    logic ins_move;
    logic no_points;
    logic srch_done;
    logic cnt_more;
  } mcws_sts_t;
endpackage

FILE: hw/rtl/min_cover_window_search.sv
`timescale 1ns / 1ps
// Minimum covering window search. Points stream in over valid/stall; each
// is insertion-sorted into a single-port column memory, with the input
// stalled meanwhile; once the memory is full, further points are dropped
// and overflow is flagged. On the point marked last, a binary search over
// the side runs about log2(board_width) rounds (none if no point is
// stored), each a greedy pass through the memory, then one result is
// offered and the input stays stalled until it is taken.
// Config must be written only while idle; the block itself leaves this unenforced.
module min_cover_window_search import mcws_pkg::*; #(
  parameter int unsigned MaxPoints = MaxPointsDefault,
  parameter int unsigned CoordBits = CoordBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [CoordBits-1:0] height_pos_i,
  input  logic [CoordBits-1:0] column_pos_i,
  input  logic                 last_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [SideBits-1:0]  side_length_o,
  output logic                 overflow_o,
  input  logic                 cfg_we_i,
  input  logic [0:0]           cfg_idx_i,
  input  logic [SideBits-1:0]  cfg_data_i
);
  logic [WinBits-1:0]  max_windows_q;
  logic [SideBits-1:0] board_width_q;
  mcws_cmd_t cmd;
  mcws_sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_windows_q <= WinBits'(1);
      board_width_q <= '1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegMaxWindows: max_windows_q <= cfg_data_i[WinBits-1:0];
        RegBoardWidth: board_width_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mcws_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .last_i,
    .out_valid_o, .out_stall_i,
    .cmd_o(cmd), .sts_i(sts)
  );

  mcws_datapath #(.MaxPoints(MaxPoints), .CoordBits(CoordBits)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .height_pos_i, .column_pos_i,
    .max_windows_i(max_windows_q), .board_width_i(board_width_q),
    .side_length_o, .overflow_o
  );
endmodule

FILE: hw/rtl/mcws_datapath.sv
`timescale 1ns / 1ps
module mcws_datapath import mcws_pkg::*; #(
  parameter int unsigned MaxPoints = MaxPointsDefault,
  parameter int unsigned CoordBits = CoordBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mcws_cmd_t            cmd_i,
  output mcws_sts_t            sts_o,
  input  logic [CoordBits-1:0] height_pos_i,
  input  logic [CoordBits-1:0] column_pos_i,
  input  logic [WinBits-1:0]   max_windows_i,
  input  logic [SideBits-1:0]  board_width_i,
  output logic [SideBits-1:0]  side_length_o,
  output logic                 overflow_o
);
  localparam int unsigned AddrBits = $clog2(MaxPoints);
  localparam int unsigned CntBits = $clog2(MaxPoints + 1);
  localparam int unsigned SrchBits = (CoordBits > SideBits ? CoordBits : SideBits) + 2;
  localparam int unsigned CmpBits = (CntBits + 1 > WinBits) ? CntBits + 1 : WinBits;

  logic [CoordBits-1:0] mem_q [MaxPoints];
  logic [CoordBits-1:0] rd_data_q;
  logic [CntBits-1:0]   count_q;
  logic [CoordBits-1:0] max_h_q;
  logic                 drop_q;
  logic [CoordBits-1:0] col_q;
  logic [CntBits-1:0]   idx_q;
  logic [SrchBits-1:0]  lo_q, hi_q, mid_q;
  logic [SideBits-1:0]  best_q;
  logic [CoordBits:0]   start_q;
  logic [CntBits:0]     used_q;
  logic [CntBits-1:0]   rd_idx;
  logic [SrchBits-1:0]  sum;
  logic                 fits;

  assign sum = lo_q + hi_q;
  assign fits = CmpBits'(used_q) <= CmpBits'(max_windows_i);
  assign rd_idx = cmd_i.ins_rd ? idx_q - 1'b1 : idx_q;

  assign sts_o.store_full = count_q == CntBits'(MaxPoints);
  assign sts_o.ins_at_bottom = idx_q == '0;
  assign sts_o.ins_move = rd_data_q > col_q;
  assign sts_o.no_points = count_q == '0;
  assign sts_o.srch_done = lo_q > hi_q;
  assign sts_o.cnt_more = idx_q < count_q;

  // Memory: one write, one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_rd || cmd_i.cnt_rd) begin
      rd_data_q <= mem_q[rd_idx[AddrBits-1:0]];
    end
    if (cmd_i.ins_shift) begin
      mem_q[idx_q[AddrBits-1:0]] <= rd_data_q;
    end else if (cmd_i.ins_place) begin
      mem_q[idx_q[AddrBits-1:0]] <= col_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      max_h_q <= '0;
      drop_q <= 1'b0;
    end else if (cmd_i.clear_set) begin
      count_q <= '0;
      max_h_q <= '0;
      drop_q <= 1'b0;
    end else if (cmd_i.load_pt) begin
      if (count_q == CntBits'(MaxPoints)) begin
        drop_q <= 1'b1;
      end else if (height_pos_i > max_h_q) begin
        max_h_q <= height_pos_i;
      end
    end else if (cmd_i.ins_place) begin
      count_q <= count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pt) begin
      col_q <= column_pos_i;
      idx_q <= count_q;
    end else if (cmd_i.ins_shift) begin
      idx_q <= idx_q - 1'b1;
    end else if (cmd_i.cnt_start) begin
      idx_q <= CntBits'(1);
      used_q <= (CntBits + 1)'(1);
      start_q <= {1'b0, rd_data_q};
    end else if (cmd_i.cnt_step) begin
      idx_q <= idx_q + 1'b1;
      if (SrchBits'(rd_data_q) >= SrchBits'(start_q) + mid_q) begin
        used_q <= used_q + 1'b1;
        start_q <= {1'b0, rd_data_q};
      end
    end
    if (cmd_i.srch_init) begin
      lo_q <= (max_h_q == '0) ? SrchBits'(1) : SrchBits'(max_h_q);
      hi_q <= SrchBits'(board_width_i);
      best_q <= board_width_i;
      idx_q <= '0;
    end else if (cmd_i.srch_mid) begin
      mid_q <= sum >> 1;
      idx_q <= '0;
    end else if (cmd_i.srch_dec) begin
      // rewind so the next round's first read hits entry zero
      idx_q <= '0;
      if (fits) begin
        best_q <= mid_q[SideBits-1:0];
        hi_q <= mid_q - 1'b1;
      end else begin
        lo_q <= mid_q + 1'b1;
      end
    end
  end

  assign side_length_o = count_q == '0 ? '0 : best_q;
  assign overflow_o = drop_q;
endmodule

FILE: hw/rtl/mcws_ctrl.sv
`timescale 1ns / 1ps
module mcws_ctrl import mcws_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  logic      last_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output mcws_cmd_t cmd_o,
  input  mcws_sts_t sts_i
);
  mcws_state_e state_q, state_d;
  logic last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      last_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.load_pt) last_q <= last_i;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_stall_o = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_pt = 1'b1;
          if (sts_i.store_full) begin
            state_d = last_i ? StSrchInit : StIdle;
          end else if (sts_i.no_points) begin
            state_d = StInsChk;
          end else begin
            state_d = StInsRd;
          end
        end
      end
      StInsRd: begin
        if (sts_i.ins_at_bottom) begin
          cmd_o.ins_place = 1'b1;
          state_d = last_q ? StSrchInit : StIdle;
        end else begin
          cmd_o.ins_rd = 1'b1;
          state_d = StInsChk;
        end
      end
      StInsChk: begin
        if (!sts_i.ins_at_bottom && sts_i.ins_move) begin
          cmd_o.ins_shift = 1'b1;
          state_d = StInsRd;
        end else begin
          cmd_o.ins_place = 1'b1;
          state_d = last_q ? StSrchInit : StIdle;
        end
      end
      StSrchInit: begin
        cmd_o.srch_init = 1'b1;
        state_d = StSrchMid;
      end
      StSrchMid: begin
        if (sts_i.srch_done || sts_i.no_points) begin
          state_d = StOut;
        end else begin
          cmd_o.srch_mid = 1'b1;
          cmd_o.cnt_rd = 1'b1;
          state_d = StCntStart;
        end
      end
      StCntStart: begin
        cmd_o.cnt_start = 1'b1;
        state_d = StCntRd;
      end
      StCntRd: begin
        if (sts_i.cnt_more) begin
          cmd_o.cnt_rd = 1'b1;
          state_d = StCntChk;
        end else begin
          state_d = StSrchDec;
        end
      end
      StCntChk: begin
        cmd_o.cnt_step = 1'b1;
        state_d = StCntRd;
      end
      StSrchDec: begin
        cmd_o.srch_dec = 1'b1;
        state_d = StSrchMid;
      end
      StOut: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          cmd_o.clear_set = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken during result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o) else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.ins_shift, cmd_o.ins_place, cmd_o.load_pt}))
    else $error("conflicting store commands");
endmodule
